/* hdl/rvg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvg_pkg: shared types and constants
// Command codes, draw widths, the queue entry and the sequencer states of the
// permutation random generator.
// ----------------------------------------------------------------------------
package rvg_pkg;

   localparam int KEY_BYTES_DEFAULT      = 64;
   localparam int SCHEDULE_STEPS_DEFAULT = 768;
   localparam int TABLE_SIZE             = 256;
   localparam int QUEUE_DEPTH            = 2;
   localparam int KEY_ADDR_W             = 9;
   localparam int REQ_DATA_W             = 88;
   localparam int VALUE_W                = 64;

   // Operation codes as they arrive on the request tuser.
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SCHED  = 2'd1;
   localparam logic [1:0] OP_DRAW   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Draw width codes as they arrive on the request tdata. The spare code
   // draws 64 bits like the 64-bit code.
   localparam logic [1:0] DW_CODE_8   = 2'd0;
   localparam logic [1:0] DW_CODE_32  = 2'd1;
   localparam logic [1:0] DW_CODE_64  = 2'd2;
   localparam logic [1:0] DW_CODE_ALT = 2'd3;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_SCHED,
      CMD_DRAW
   } cmd_kind_type;

   typedef enum logic [1:0] {
      DW_8,
      DW_32,
      DW_64
   } draw_width_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [KEY_ADDR_W-1:0]   key_addr;
      logic [7:0]              key_byte;
      draw_width_type          width;
      logic [VALUE_W-1:0]      range;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FILL,
      ST_KA,
      ST_KB,
      ST_KC,
      ST_KD,
      ST_KE,
      ST_LIMWAIT,
      ST_BA,
      ST_BB,
      ST_BC,
      ST_BD,
      ST_BE,
      ST_BF,
      ST_BG,
      ST_CHECK,
      ST_MODWAIT,
      ST_DONE
   } state_type;

endpackage

/* hdl/rvg_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvg_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rvg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/rvg_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvg_front: request decode and command queue
// Classifies request words, drops those that do nothing and queues the rest.
// ----------------------------------------------------------------------------
module rvg_front
   import rvg_pkg::*;
#(
   parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output cmd_type               cmd
);

   cmd_type    queue_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    entry;
   logic       keep;
   logic       push, pop;

   logic       key_set;
   logic [5:0] key_index;

   assign key_set   = req_tdata[0];
   assign key_index = req_tdata[6:1];

   always_comb begin
      entry          = '0;
      keep           = 1'b0;
      entry.key_byte = req_tdata[14:7];
      entry.range    = req_tdata[80:17];
      entry.key_addr = key_set ? KEY_ADDR_W'(KEY_BYTES) + KEY_ADDR_W'(key_index)
                               : KEY_ADDR_W'(key_index);
      unique case (req_tdata[16:15])
         DW_CODE_8:  entry.width = DW_8;
         DW_CODE_32: entry.width = DW_32;
         default:    entry.width = DW_64;
      endcase
      unique case (req_tuser)
         OP_LOAD: begin
            entry.kind = CMD_LOAD;
            keep       = (32'(key_index) < KEY_BYTES);
         end
         OP_SCHED: begin
            entry.kind = CMD_SCHED;
            keep       = 1'b1;
         end
         OP_DRAW: begin
            entry.kind = CMD_DRAW;
            keep       = 1'b1;
         end
         default: begin
            entry.kind = CMD_LOAD;
            keep       = 1'b0;
         end
      endcase
   end

   assign req_tready = (count_ff != 2'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && keep;
   assign cmd_valid  = (count_ff != 2'd0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

/* hdl/rvg_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvg_mod: iterative 64-bit remainder unit
// Restoring division, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rvg_mod
   import rvg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] dividend,
   input  logic [VALUE_W-1:0] divisor,
   output mod_stat_type       stat,
   output logic [VALUE_W-1:0] remainder
);

   logic [VALUE_W-1:0] num_ff, num_in;
   logic [VALUE_W-1:0] den_ff, den_in;
   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [VALUE_W:0]   trial;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[VALUE_W-1]};
      if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = 7'(VALUE_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = VALUE_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = VALUE_W'(trial);
         end
         num_in = num_ff << 1;
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

/* hdl/rvg_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvg_back: permutation sequencer
// Runs key loads, the key schedule and draws against the table RAM, with
// rejection sampling and reduction through the remainder unit.
// ----------------------------------------------------------------------------
module rvg_back
   import rvg_pkg::*;
#(
   parameter int KEY_BYTES      = KEY_BYTES_DEFAULT,
   parameter int SCHEDULE_STEPS = SCHEDULE_STEPS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  cmd_type            cmd,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [VALUE_W-1:0] out_value
);

   localparam int KAW = $clog2(2 * KEY_BYTES);
   localparam int KCW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam int LW  = $clog2(SCHEDULE_STEPS);

   state_type          state_ff, state_in;
   logic [7:0]         i_ff, i_in;
   logic [7:0]         j_ff, j_in;
   logic [7:0]         pi_ff, pi_in;
   logic [7:0]         pj_ff, pj_in;
   logic [7:0]         fill_ff, fill_in;
   logic [LW-1:0]      l_ff, l_in;
   logic [KCW-1:0]     kidx_ff, kidx_in;
   logic               set_ff, set_in;
   logic [2:0]         nbyte_ff, nbyte_in;
   logic [2:0]         last_ff, last_in;
   logic               ranged_ff, ranged_in;
   draw_width_type     width_ff, width_in;
   logic [VALUE_W-1:0] rng_ff, rng_in;
   logic [VALUE_W-1:0] lim_ff, lim_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [VALUE_W-1:0] res_ff, res_in;
   logic               out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;

   logic               p_we;
   logic [7:0]         p_waddr, p_wdata, p_raddr, p_rdata;
   logic               k_we;
   logic [KAW-1:0]     k_waddr, k_raddr;
   logic [7:0]         k_rdata;

   logic               mod_start;
   logic [VALUE_W-1:0] mod_num, mod_den, mod_rem;
   mod_stat_type       mod_stat;

   logic [VALUE_W-1:0] cmd_rng;

   rvg_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_perm_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   rvg_ram #(.WIDTH(8), .DEPTH(2 * KEY_BYTES)) u_key_ram (
      .clock   (clock),
      .wr_en   (k_we),
      .wr_addr (k_waddr),
      .wr_data (cmd.key_byte),
      .rd_addr (k_raddr),
      .rd_data (k_rdata)
   );

   rvg_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_num),
      .divisor   (mod_den),
      .stat      (mod_stat),
      .remainder (mod_rem)
   );

   assign cmd_rng = (cmd.width == DW_32) ? {32'b0, cmd.range[31:0]} : cmd.range;
   assign k_waddr = KAW'(cmd.key_addr);
   assign k_raddr = set_ff ? KAW'(KEY_BYTES) + KAW'(kidx_ff) : KAW'(kidx_ff);

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pi_in        = pi_ff;
      pj_in        = pj_ff;
      fill_in      = fill_ff;
      l_in         = l_ff;
      kidx_in      = kidx_ff;
      set_in       = set_ff;
      nbyte_in     = nbyte_ff;
      last_in      = last_ff;
      ranged_in    = ranged_ff;
      width_in     = width_ff;
      rng_in       = rng_ff;
      lim_in       = lim_ff;
      val_in       = val_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_value_in = out_value_ff;
      cmd_ready    = 1'b0;
      p_we         = 1'b0;
      p_waddr      = i_ff;
      p_wdata      = pj_ff;
      p_raddr      = i_ff;
      k_we         = 1'b0;
      mod_start    = 1'b0;
      mod_num      = val_ff;
      mod_den      = rng_ff;

      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_LOAD: begin
                     k_we = 1'b1;
                  end
                  CMD_SCHED: begin
                     fill_in  = 8'd0;
                     state_in = ST_FILL;
                  end
                  default: begin
                     width_in  = cmd.width;
                     rng_in    = cmd_rng;
                     val_in    = '0;
                     nbyte_in  = 3'd0;
                     lim_in    = '0;
                     ranged_in = (cmd.width != DW_8) && (cmd_rng != '0);
                     unique case (cmd.width)
                        DW_8:    last_in = 3'd0;
                        DW_32:   last_in = 3'd3;
                        default: last_in = 3'd7;
                     endcase
                     if ((cmd.width != DW_8) && (cmd_rng != '0)) begin
                        // Largest multiple of the range: 2^n - (2^n mod range).
                        mod_start = 1'b1;
                        mod_den   = cmd_rng;
                        mod_num   = (cmd.width == DW_32)
                                    ? {32'b0, 32'(32'd0 - cmd.range[31:0])}
                                    : (64'd0 - cmd.range);
                        state_in  = ST_LIMWAIT;
                     end else begin
                        state_in = ST_BA;
                     end
                  end
               endcase
            end
         end
         ST_FILL: begin
            p_we    = 1'b1;
            p_waddr = fill_ff;
            p_wdata = fill_ff;
            fill_in = fill_ff + 8'd1;
            if (fill_ff == 8'hFF) begin
               l_in     = '0;
               kidx_in  = '0;
               set_in   = 1'b0;
               state_in = ST_KA;
            end
         end
         ST_KA: begin
            p_raddr  = l_ff[7:0];
            i_in     = l_ff[7:0];
            state_in = ST_KB;
         end
         ST_KB: begin
            pi_in    = p_rdata;
            p_raddr  = j_ff + p_rdata + k_rdata;
            state_in = ST_KC;
         end
         ST_KC: begin
            j_in     = p_rdata;
            p_raddr  = p_rdata;
            state_in = ST_KD;
         end
         ST_KD: begin
            p_we     = 1'b1;
            p_waddr  = i_ff;
            p_wdata  = p_rdata;
            state_in = ST_KE;
         end
         ST_KE: begin
            p_we    = 1'b1;
            p_waddr = j_ff;
            p_wdata = pi_ff;
            l_in    = l_ff + LW'(1);
            kidx_in = (32'(kidx_ff) == KEY_BYTES - 1) ? '0 : kidx_ff + KCW'(1);
            state_in = ST_KA;
            if (l_ff == LW'(SCHEDULE_STEPS - 1)) begin
               l_in    = '0;
               kidx_in = '0;
               if (!set_ff) begin
                  set_in = 1'b1;
               end else begin
                  i_in     = 8'd0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LIMWAIT: begin
            if (mod_stat.done) begin
               lim_in   = (width_ff == DW_32) ? {32'b0, 32'(32'd0 - mod_rem[31:0])}
                                              : (64'd0 - mod_rem);
               state_in = ST_BA;
            end
         end
         ST_BA: begin
            p_raddr  = i_ff;
            state_in = ST_BB;
         end
         ST_BB: begin
            pi_in    = p_rdata;
            p_raddr  = j_ff + p_rdata;
            state_in = ST_BC;
         end
         ST_BC: begin
            j_in     = p_rdata;
            p_raddr  = p_rdata;
            state_in = ST_BD;
         end
         ST_BD: begin
            pj_in    = p_rdata;
            p_raddr  = p_rdata;
            state_in = ST_BE;
         end
         ST_BE: begin
            p_raddr  = p_rdata + 8'd1;
            state_in = ST_BF;
         end
         ST_BF: begin
            val_in   = val_ff | (VALUE_W'(p_rdata) << {nbyte_ff, 3'b000});
            p_we     = 1'b1;
            p_waddr  = i_ff;
            p_wdata  = pj_ff;
            state_in = ST_BG;
         end
         ST_BG: begin
            p_we     = 1'b1;
            p_waddr  = j_ff;
            p_wdata  = pi_ff;
            i_in     = i_ff + 8'd1;
            nbyte_in = nbyte_ff + 3'd1;
            state_in = (nbyte_ff == last_ff) ? ST_CHECK : ST_BA;
         end
         ST_CHECK: begin
            if (!ranged_ff) begin
               res_in   = val_ff;
               state_in = ST_DONE;
            end else if ((lim_ff != '0) && (val_ff >= lim_ff)) begin
               val_in   = '0;
               nbyte_in = 3'd0;
               state_in = ST_BA;
            end else begin
               mod_start = 1'b1;
               state_in  = ST_MODWAIT;
            end
         end
         ST_MODWAIT: begin
            if (mod_stat.done) begin
               res_in   = mod_rem;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               out_value_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= 8'd0;
         j_ff         <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         out_valid_ff <= out_valid_in;
      end
      pi_ff        <= pi_in;
      pj_ff        <= pj_in;
      fill_ff      <= fill_in;
      l_ff         <= l_in;
      kidx_ff      <= kidx_in;
      set_ff       <= set_in;
      nbyte_ff     <= nbyte_in;
      last_ff      <= last_in;
      ranged_ff    <= ranged_in;
      width_ff     <= width_in;
      rng_ff       <= rng_in;
      lim_ff       <= lim_in;
      val_ff       <= val_in;
      res_ff       <= res_in;
      out_value_ff <= out_value_in;
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;

   // The remainder unit is never restarted while it is still working.
   a_mod_start_idle: assert property (@(posedge clock) disable iff (reset)
      mod_start |-> !mod_stat.busy)
      else $error("remainder unit started while busy");

   // A finished draw waits while the output register still holds a word.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_valid_ff && !out_ready) |=> (state_ff == ST_DONE))
      else $error("result left before output register was free");

   // The end of the key schedule leaves i cleared.
   a_sched_clears_i: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_KE && state_ff == ST_IDLE) |-> (i_ff == 8'd0))
      else $error("i not cleared after key schedule");

endmodule

/* hdl/rc4_variant_random_generator_core.sv */
`timescale 1ns / 1ps
// A raw draw of n bytes runs the table steps once per byte; a ranged draw adds the
//   limit and the reduction in the remainder unit, and each rejection draws all n
//   bytes again. A load only writes the key RAM; a key schedule fills the table
//   and then runs SCHEDULE_STEPS steps in each of its two passes.
// Throughput is one command at a time, set by the single table RAM port pair.
// Reset is synchronous and active high; it empties the queue and clears i and j.
// ----------------------------------------------------------------------------
// rc4_variant_random_generator_core: keyed permutation random generator
// Loads key bytes, runs a two-pass key schedule and draws 8, 32 or 64 bit
// values; 32 and 64 bit draws may be reduced into a range with rejection sampling.
// ----------------------------------------------------------------------------
module rc4_variant_random_generator_core
   import rvg_pkg::*;
#(
   parameter int KEY_BYTES      = KEY_BYTES_DEFAULT,
   parameter int SCHEDULE_STEPS = SCHEDULE_STEPS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0 up: key_set[0], key_index[6:1], key_byte[14:7],
   // draw_width[16:15], range[80:17], zero fill[87:81].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0 up: operation[1:0].
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0 up: value[63:0].
   output logic [VALUE_W-1:0]    rsp_tdata
);

   // The front decodes each request word and queues the useful ones; the requester
   // is held during a long schedule or draw only once the two-entry queue is full.
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   rvg_front #(.KEY_BYTES(KEY_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   // The back holds the table and key RAMs and the remainder unit; its output
   // register lets it return to the queue as soon as the result is parked.
   rvg_back #(
      .KEY_BYTES      (KEY_BYTES),
      .SCHEDULE_STEPS (SCHEDULE_STEPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (rsp_tdata)
   );

endmodule
